### design/assert_macros.svh
// Assertion macros included by the list unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies a consequence in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Condition in this cycle implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/blidf_pkg.sv
package blidf_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_SIZE   = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_COMMIT = 1'b1
   } state_type;

   // request payload
   typedef struct packed {
      op_type             operation;
      logic signed [31:0] value;
   } req_type;

   // result payload
   typedef struct packed {
      status_type  status;
      logic [3:0]  position;
      logic [4:0]  count;
   } rsp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic capture;   // compare key and latch the match flag
      logic load;      // write key into this cell
      logic shift;     // take neighbour's entry if at or past the first match
   } cell_ctl_type;

endpackage

### design/blidf_cell.sv
module blidf_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  blidf_pkg::cell_ctl_type ctl,
   input  logic                   occupied,
   input  logic [VALUE_WIDTH-1:0] key,
   input  logic [VALUE_WIDTH-1:0] neighbour_value,
   input  logic                   seen_in,
   output logic [VALUE_WIDTH-1:0] entry_value,
   output logic                   seen_out,
   output logic                   first_hit
);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   match_ff;
   logic                   match_in;

   // compare and load / shift selection
   always_comb begin
      match_in = match_ff;
      if (ctl.capture) begin
         match_in = occupied && (entry_ff == key);
      end
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = key;
      end else if (ctl.shift && (seen_in || match_ff)) begin
         entry_in = neighbour_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   // priority chain: first match is the one with no match below it
   assign seen_out    = seen_in | match_ff;
   assign first_hit   = match_ff & ~seen_in;
   assign entry_value = entry_ff;

endmodule

### design/bounded_list_insert_delete_find_unit.sv
// A request is accepted when start is high in the idle state: the cell row captures
// the compare, and the result is registered at the end of the commit state.
// A new request is accepted only in the idle state; busy is high for the commit cycle,
// which follows from the compare-then-shift pass through the cell row.
// The receiver cannot stall: rsp_valid lasts exactly one cycle.
// Reset (synchronous, active high) empties the list and clears the sequencer;
// stored entries are not cleared.
`include "assert_macros.svh"

module bounded_list_insert_delete_find_unit #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  blidf_pkg::req_type req_payload,
   output logic               rsp_valid,
   output blidf_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   blidf_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   blidf_pkg::op_type       op_ff, op_in;
   logic [VALUE_WIDTH-1:0]  key_ff, key_in;
   blidf_pkg::rsp_type      rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [VALUE_WIDTH-1:0]  port_key;
   logic [VALUE_WIDTH-1:0]  cell_key;
   logic [VALUE_WIDTH-1:0]  entry_w [CAPACITY];
   logic [CAPACITY:0]       seen_w;
   logic [CAPACITY-1:0]     first_w;
   logic [CAPACITY-1:0]     load_sel;
   blidf_pkg::cell_ctl_type cell_ctl [CAPACITY];
   logic                    capture;
   logic                    shift;
   logic                    do_load;
   logic                    found;
   logic [IDX_W-1:0]        hit_idx;
   logic [31:0]             hit_wide;

   // request value sign-extended or cut to the stored width
   generate
      if (VALUE_WIDTH <= 32) begin : g_key_cut
         assign port_key = req_payload.value[VALUE_WIDTH-1:0];
      end else begin : g_key_ext
         assign port_key = {{(VALUE_WIDTH-32){req_payload.value[31]}}, req_payload.value};
      end
   endgenerate

   // compare against the incoming key, load the held key
   assign cell_key  = (state_ff == blidf_pkg::ST_IDLE) ? port_key : key_ff;
   assign seen_w[0] = 1'b0;
   assign found     = seen_w[CAPACITY];

   // row of cells
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [VALUE_WIDTH-1:0] next_value;
         if (i < CAPACITY - 1) begin : g_mid
            assign next_value = entry_w[i+1];
         end else begin : g_end
            assign next_value = entry_w[i];
         end
         assign load_sel[i] = (count_ff == CNT_W'(i));
         assign cell_ctl[i] = '{capture, do_load & load_sel[i], shift};
         blidf_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
         ) u_cell (
            .clock          (clock),
            .ctl            (cell_ctl[i]),
            .occupied       (CNT_W'(i) < count_ff),
            .key            (cell_key),
            .neighbour_value(next_value),
            .seen_in        (seen_w[i]),
            .entry_value    (entry_w[i]),
            .seen_out       (seen_w[i+1]),
            .first_hit      (first_w[i])
         );
      end
   endgenerate

   // encode the first match position
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_w[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   assign hit_wide = 32'(hit_idx);

   // sequencer: next state, commit and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      capture      = 1'b0;
      shift        = 1'b0;
      do_load      = 1'b0;
      busy         = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         blidf_pkg::ST_IDLE: begin
            if (start) begin
               capture  = 1'b1;
               op_in    = req_payload.operation;
               key_in   = port_key;
               state_in = blidf_pkg::ST_COMMIT;
            end
         end
         blidf_pkg::ST_COMMIT: begin
            busy            = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = blidf_pkg::ST_IDLE;
            rsp_in.status   = blidf_pkg::STATUS_OK;
            rsp_in.position = '0;
            case (op_ff)
               blidf_pkg::OP_INSERT: begin
                  if (count_ff < CNT_W'(CAPACITY)) begin
                     do_load  = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     rsp_in.status = blidf_pkg::STATUS_FULL;
                  end
               end
               blidf_pkg::OP_DELETE: begin
                  if (found) begin
                     shift    = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     rsp_in.status = blidf_pkg::STATUS_MISSING;
                  end
               end
               blidf_pkg::OP_FIND: begin
                  if (found) begin
                     rsp_in.position = hit_wide[3:0];
                  end else begin
                     rsp_in.status = blidf_pkg::STATUS_MISSING;
                  end
               end
               default: begin
               end
            endcase
            rsp_in.count = 5'(count_in);
         end
         default: begin
            state_in = blidf_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blidf_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_busy_result, clock, reset, busy, rsp_valid && !busy)
   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_SAME(a_full_count, clock, reset, rsp_valid && (rsp_payload.status == blidf_pkg::STATUS_FULL), count_ff == CNT_W'(CAPACITY))

endmodule
